@@ rtl/core/nai_pkg.sv @@
// ----------------------------------------------------------------------------
// N-list ancestor intersection package
// Shared widths, payload structs, opcodes and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package nai_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int CODE_W     = 20;
    localparam int CNT_W      = 24;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [1:0] op;
        code_t      pre_number;
        code_t      post_number;
        cnt_t       node_count;
    } in_t;

    typedef struct packed {
        logic  entry_valid;
        code_t entry_pre;
        code_t entry_post;
        cnt_t  entry_count;
        cnt_t  total_count;
        logic  is_frequent;
        logic  list_overflow;
        logic  last;
    } out_t;

    typedef struct packed {
        code_t pre;
        code_t post;
    } node_a_t;

    typedef struct packed {
        code_t pre;
        code_t post;
        cnt_t  cnt;
    } node_b_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic run_start;
        logic merge_read;
        logic merge_step;
        logic merge_done;
        logic emit_read;
        logic emit_load;
    } nai_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic merge_more;
        logic out_free;
        logic emit_last;
    } nai_status_t;

    function automatic cnt_t sat_add(input cnt_t x, input cnt_t y);
        logic [CNT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/nlist_ancestor_intersection.sv @@
// ----------------------------------------------------------------------------
// N-list ancestor intersection
// Loads two pre/post coded node lists and merges them, summing the B counts
// under each ancestor A node.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Direction  Payload
//  input     s_valid s_ready s_data      in         in_t (op, codes, count)
//  result    m_valid m_ready m_data      out        out_t (entry, totals, flags)
//  config    cfg_wr_en cfg_wr_data       in         min_support, 24 bit
//
// A run repeats merge steps (registered list memory read, then compare), at
// most len_a + len_b steps, then emits each result transaction by a hit
// memory read and an output register load that waits out any m_ready
// stall. Input is held off from the run until the final result is loaded
// into the output register. Reset is synchronous and clears list lengths,
// the overflow flag and min_support; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nlist_ancestor_intersection
    import nai_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data,
    input  wire logic cfg_wr_en,
    input  wire cnt_t cfg_wr_data
);

    nai_cmd_t    cmd;
    nai_status_t st;

    nai_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    nai_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/nai_ctrl.sv @@
// ----------------------------------------------------------------------------
// N-list ancestor intersection controller
// Sequences list loads, the two-pointer merge and the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nai_ctrl
    import nai_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic [1:0]  s_op,
    output logic             s_ready,
    input  wire nai_status_t st,
    output nai_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MREAD,
        ST_MCMP,
        ST_EREAD,
        ST_ELOAD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_LOAD_A || s_op == OP_LOAD_B) begin
                        cmd.load = 1'b1;
                    end else if (s_op == OP_RUN) begin
                        cmd.run_start = 1'b1;
                        state_next    = ST_MREAD;
                    end
                end
            end
            ST_MREAD: begin
                if (st.merge_more) begin
                    cmd.merge_read = 1'b1;
                    state_next     = ST_MCMP;
                end else begin
                    cmd.merge_done = 1'b1;
                    state_next     = ST_EREAD;
                end
            end
            ST_MCMP: begin
                cmd.merge_step = 1'b1;
                state_next     = ST_MREAD;
            end
            ST_EREAD: begin
                cmd.emit_read = 1'b1;
                state_next    = ST_ELOAD;
            end
            ST_ELOAD: begin
                if (st.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = st.emit_last ? ST_IDLE : ST_EREAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nai_datapath.sv @@
// ----------------------------------------------------------------------------
// N-list ancestor intersection datapath
// List memories, merge pointers, hit memory, accumulators and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nai_datapath
    import nai_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire in_t        s_data,
    input  wire logic       cfg_wr_en,
    input  wire cnt_t       cfg_wr_data,
    input  wire nai_cmd_t   cmd,
    output nai_status_t     st,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data
);

    node_a_t list_a_mem [LIST_DEPTH];
    node_b_t list_b_mem [LIST_DEPTH];
    node_b_t hit_mem    [LIST_DEPTH];

    logic [LEN_W-1:0] len_a_reg, len_b_reg;
    logic [LEN_W-1:0] i_reg, j_reg, n_reg, k_reg;
    logic             ovf_reg, run_ovf_reg;
    cnt_t             min_support_reg;
    node_a_t          a_rd_reg;
    node_b_t          b_rd_reg;
    node_b_t          h_rd_reg;
    code_t            cur_pre_reg;
    node_b_t          cur_reg;
    cnt_t             total_reg;
    logic             m_valid_reg;
    out_t             out_reg;

    logic             a_lt, is_anc, same_entry;
    logic [LEN_W-1:0] n_dec;
    logic [IDX_W-1:0] hit_addr;
    node_b_t          hit_wdata;
    logic             n_zero;
    cnt_t             total_next;
    out_t             out_next;

    assign a_lt       = a_rd_reg.pre < b_rd_reg.pre;
    assign is_anc     = a_lt && (a_rd_reg.post > b_rd_reg.post);
    assign same_entry = (n_reg != '0) && (cur_pre_reg == a_rd_reg.pre);
    assign n_dec      = n_reg - LEN_W'(1);
    assign hit_addr   = same_entry ? n_dec[IDX_W-1:0] : n_reg[IDX_W-1:0];

    always_comb begin
        if (same_entry) begin
            hit_wdata = '{pre: cur_reg.pre, post: cur_reg.post,
                          cnt: sat_add(cur_reg.cnt, b_rd_reg.cnt)};
        end else begin
            hit_wdata = '{pre: a_rd_reg.pre, post: a_rd_reg.post, cnt: b_rd_reg.cnt};
        end
    end

    assign n_zero        = (n_reg == '0);
    assign st.merge_more = (i_reg < len_a_reg) && (j_reg < len_b_reg);
    assign st.out_free   = !m_valid_reg || m_ready;
    assign st.emit_last  = n_zero || (k_reg == n_dec);

    assign total_next = sat_add(total_reg, h_rd_reg.cnt);

    always_comb begin
        out_next               = '0;
        out_next.list_overflow = run_ovf_reg;
        out_next.last          = st.emit_last;
        if (n_zero) begin
            out_next.is_frequent = (min_support_reg == '0);
        end else begin
            out_next.entry_valid = 1'b1;
            out_next.entry_pre   = h_rd_reg.pre;
            out_next.entry_post  = h_rd_reg.post;
            out_next.entry_count = h_rd_reg.cnt;
            out_next.total_count = total_next;
            out_next.is_frequent = st.emit_last && (total_next >= min_support_reg);
        end
    end

    // Memories: written and read in clocked blocks, read data registered.
    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.op == OP_LOAD_A && len_a_reg != LEN_W'(LIST_DEPTH)) begin
            list_a_mem[len_a_reg[IDX_W-1:0]] <= '{pre: s_data.pre_number,
                                                 post: s_data.post_number};
        end
        if (cmd.load && s_data.op == OP_LOAD_B && len_b_reg != LEN_W'(LIST_DEPTH)) begin
            list_b_mem[len_b_reg[IDX_W-1:0]] <= '{pre: s_data.pre_number,
                                                 post: s_data.post_number,
                                                 cnt: s_data.node_count};
        end
        if (cmd.merge_read) begin
            a_rd_reg <= list_a_mem[i_reg[IDX_W-1:0]];
            b_rd_reg <= list_b_mem[j_reg[IDX_W-1:0]];
        end
        if (cmd.merge_step && is_anc) begin
            hit_mem[hit_addr] <= hit_wdata;
            cur_reg           <= hit_wdata;
            cur_pre_reg       <= hit_wdata.pre;
        end
        if (cmd.emit_read) begin
            h_rd_reg <= hit_mem[k_reg[IDX_W-1:0]];
        end
        if (cmd.emit_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg       <= '0;
            len_b_reg       <= '0;
            ovf_reg         <= 1'b0;
            run_ovf_reg     <= 1'b0;
            min_support_reg <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            n_reg           <= '0;
            k_reg           <= '0;
            total_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_support_reg <= cfg_wr_data;
            end
            if (cmd.load && s_data.op == OP_LOAD_A) begin
                if (len_a_reg == LEN_W'(LIST_DEPTH)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    len_a_reg <= len_a_reg + LEN_W'(1);
                end
            end
            if (cmd.load && s_data.op == OP_LOAD_B) begin
                if (len_b_reg == LEN_W'(LIST_DEPTH)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    len_b_reg <= len_b_reg + LEN_W'(1);
                end
            end
            if (cmd.run_start) begin
                run_ovf_reg <= ovf_reg;
                i_reg       <= '0;
                j_reg       <= '0;
                n_reg       <= '0;
                k_reg       <= '0;
                total_reg   <= '0;
            end
            if (cmd.merge_step) begin
                if (is_anc) begin
                    j_reg <= j_reg + LEN_W'(1);
                    if (!same_entry) begin
                        n_reg <= n_reg + LEN_W'(1);
                    end
                end else if (a_lt) begin
                    i_reg <= i_reg + LEN_W'(1);
                end else begin
                    j_reg <= j_reg + LEN_W'(1);
                end
            end
            if (cmd.merge_done) begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.emit_load) begin
                k_reg       <= k_reg + LEN_W'(1);
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // Every entry needs at least one matched B node.
    a_entries_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= j_reg)
        else $error("more result entries than consumed B nodes");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_reg.entry_valid |-> out_reg.last)
        else $error("empty-result marker without last");

    a_frequent_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.is_frequent |-> out_reg.last)
        else $error("frequent flag on a non-final transaction");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
